// ----- design/sfc_pkg.sv -----
// sfc_pkg: types and constants shared by the frame checker modules
// no dependencies; compile first
`timescale 1ns / 1ps
`default_nettype none

package sfc_pkg;

  // framing marks and minimum total frame length
  localparam logic [7:0]  HeadMark    = 8'h02;
  localparam logic [7:0]  TailMark    = 8'h03;
  localparam logic [15:0] MinFrameLen = 16'd4;

  // byte positions with a fixed meaning inside a frame
  localparam logic [15:0] PosHead  = 16'd0;
  localparam logic [15:0] PosLenHi = 16'd1;
  localparam logic [15:0] PosLenLo = 16'd2;
  localparam logic [15:0] PosFirst = 16'd3;

  // per-item status code
  typedef enum logic [1:0] {
    ST_MORE = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  // one result item
  typedef struct packed {
    status_e     status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_len;
  } result_t;

endpackage

`default_nettype wire

// ----- design/sfc_if.sv -----
// sfc_byte_if and sfc_result_if: valid/ready channels of the frame checker
// depends on sfc_pkg for the status type
`timescale 1ns / 1ps
`default_nettype none

interface sfc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfc_result_if;
  logic                 valid;
  logic                 ready;
  sfc_pkg::status_e     status;
  logic                 payload_valid;
  logic [7:0]           payload_byte;
  logic [15:0]          payload_len;

  modport source (output valid, output status, output payload_valid,
                  output payload_byte, output payload_len, input ready);
  modport sink   (input valid, input status, input payload_valid,
                  input payload_byte, input payload_len, output ready);
endinterface

`default_nettype wire

// ----- design/sfc_in_stage.sv -----
// sfc_in_stage: input register holding one received byte
// depends on sfc_if (sfc_byte_if)
`timescale 1ns / 1ps
`default_nettype none

module sfc_in_stage (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sfc_byte_if.sink   in_i,
  output logic       valid_o,
  output logic [7:0] byte_o,
  input  wire logic  ready_i
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  // stage is free when empty or when its item moves on this cycle
  assign in_i.ready = !valid_q || ready_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_i.rx_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

// ----- design/sfc_frame_core.sv -----
// sfc_frame_core: byte position and length registers with per-byte decode
// depends on sfc_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfc_frame_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  output sfc_pkg::result_t res_o
);

  logic [15:0] pos_q, pos_d;
  logic [15:0] len_q, len_d;
  logic [16:0] pos_inc;
  logic        at_tail;

  assign pos_inc = {1'b0, pos_q} + 17'd1;
  assign at_tail = (pos_inc == {1'b0, len_q});

  // decode one byte against the frame position
  always_comb begin
    pos_d = pos_q;
    len_d = len_q;
    res_o = '0;
    res_o.status = sfc_pkg::ST_MORE;
    if (pos_q == sfc_pkg::PosHead) begin
      if (byte_i != sfc_pkg::HeadMark) begin
        res_o.status = sfc_pkg::ST_ERR;
        len_d        = '0;
      end else begin
        pos_d = sfc_pkg::PosLenHi;
      end
    end else if (pos_q == sfc_pkg::PosLenHi) begin
      len_d = {byte_i, 8'h00};
      pos_d = sfc_pkg::PosLenLo;
    end else if (pos_q == sfc_pkg::PosLenLo) begin
      len_d = {len_q[15:8], byte_i};
      pos_d = sfc_pkg::PosFirst;
    end else if (pos_q == sfc_pkg::PosFirst && len_q < sfc_pkg::MinFrameLen) begin
      // length field too short to hold a frame
      res_o.status = sfc_pkg::ST_ERR;
      pos_d        = '0;
      len_d        = '0;
    end else if (at_tail) begin
      if (byte_i == sfc_pkg::TailMark) begin
        res_o.status      = sfc_pkg::ST_DONE;
        res_o.payload_len = len_q - sfc_pkg::MinFrameLen;
      end else begin
        res_o.status = sfc_pkg::ST_ERR;
      end
      pos_d = '0;
      len_d = '0;
    end else begin
      // payload byte passes through
      res_o.payload_valid = 1'b1;
      res_o.payload_byte  = byte_i;
      pos_d               = pos_inc[15:0];
    end
  end

  // frame state advances once per decoded item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      len_q <= '0;
    end else if (step_i) begin
      pos_q <= pos_d;
      len_q <= len_d;
    end
  end

`ifndef NO_ASSERTIONS
  // a finished or failed frame leaves the checker waiting for a head byte
  a_idle_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (res_o.status == sfc_pkg::ST_DONE || res_o.status == sfc_pkg::ST_ERR)
    |=> pos_q == sfc_pkg::PosHead)
    else $error("frame position not cleared after end of frame");

  // past the length field the position stays short of the latched length
  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q > sfc_pkg::PosFirst |-> pos_q < len_q && len_q > sfc_pkg::MinFrameLen)
    else $error("frame position beyond latched length");

  // payload flag only comes with a need-more status
  a_payload_more: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.payload_valid |-> res_o.status == sfc_pkg::ST_MORE)
    else $error("payload byte flagged on a terminal status");
`endif

endmodule

`default_nettype wire

// ----- design/sfc_out_stage.sv -----
// sfc_out_stage: result register driving the output channel
// depends on sfc_pkg and sfc_if (sfc_result_if)
`timescale 1ns / 1ps
`default_nettype none

module sfc_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire sfc_pkg::result_t  res_i,
  output logic                   ready_o,
  sfc_result_if.source           out_o
);

  logic             valid_q, valid_d;
  sfc_pkg::result_t res_q;
  logic             load;

  // register takes a new item when empty or being drained
  assign ready_o = !valid_q || out_o.ready;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.status        = res_q.status;
  assign out_o.payload_valid = res_q.payload_valid;
  assign out_o.payload_byte  = res_q.payload_byte;
  assign out_o.payload_len   = res_q.payload_len;

endmodule

`default_nettype wire

// ----- design/stx_len_etx_frame_checker.sv -----
// stx_len_etx_frame_checker: head/length/tail frame checker, one byte per item
// path: an accepted byte is held in the input register, then its result in the result register
// throughput: one byte per cycle while the output channel is ready, set by the input register,
//   the single decode step on the position/length registers and the result register
// reset: asynchronous, active low; clears both stages and the frame state
`timescale 1ns / 1ps
`default_nettype none

module stx_len_etx_frame_checker (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  sfc_byte_if.sink     in_i,
  sfc_result_if.source out_o
);

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             out_ready;
  logic             step;
  sfc_pkg::result_t res;

  // decode happens as the registered byte moves into the result register
  assign step = s1_valid && out_ready;

  sfc_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (s1_valid),
    .byte_o  (s1_byte),
    .ready_i (out_ready)
  );

  sfc_frame_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (s1_byte),
    .res_o  (res)
  );

  sfc_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .res_i   (res),
    .ready_o (out_ready),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
